// ----- sv/lddq_pkg.sv -----
// Shared types and codes for the list deque with sorted insert.
package lddq_pkg;

  // Operation codes carried by an input transfer
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_REAR  = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_REAR  = 3'd3;
  localparam logic [2:0] OP_SORTED    = 3'd4;
  localparam logic [2:0] OP_DISPLAY   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Store update requested of the datapath
  typedef enum logic [2:0] {
    DP_NONE      = 3'd0,
    DP_INS_FRONT = 3'd1,
    DP_INS_REAR  = 3'd2,
    DP_INS_PTR   = 3'd3,
    DP_DEL_FRONT = 3'd4,
    DP_DEL_REAR  = 3'd5
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       v_load;    // capture item value for the sorted scan
    logic       ptr_clr;
    logic       ptr_inc;
    logic       out_load;  // load the result register
    logic       out_elem;  // result carries the element under the pointer
    logic [1:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_go;    // pointer is within the list and its element is smaller than the value
    logic disp_last;  // pointer sits on the rear element
  } dp_stat_t;

endpackage

// ----- sv/lddq_dp.sv -----
// Datapath: element shift store, occupancy, scan pointer and result register.
module lddq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lddq_pkg::dp_cmd_t     cmd,
  output lddq_pkg::dp_stat_t    stat,
  input  logic signed [31:0]    in_item_value,
  output logic signed [31:0]    out_element_value,
  output logic [1:0]            out_status,
  output logic                  out_last_result,
  output logic [4:0]            out_element_count
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic signed [31:0] store_r   [DEPTH];
  logic signed [31:0] store_nxt [DEPTH];
  logic [PW-1:0]      occ_r, occ_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic signed [31:0] v_r;
  logic signed [31:0] rd_data;
  logic [PW-1:0]      ins_pos;
  logic signed [31:0] ins_val;

  logic signed [31:0] val_r;
  logic [1:0]         st_r;
  logic               last_r;
  logic [4:0]         cnt_r;

  assign rd_data = store_r[ptr_r[IW-1:0]];

  assign stat.empty     = (occ_r == '0);
  assign stat.full      = (occ_r == PW'(DEPTH));
  assign stat.scan_go   = (ptr_r < occ_r) && (rd_data < v_r);
  assign stat.disp_last = ((ptr_r + PW'(1)) == occ_r);

  always_comb begin
    ins_pos = '0;
    ins_val = in_item_value;
    case (cmd.op)
      lddq_pkg::DP_INS_REAR: ins_pos = occ_r;
      lddq_pkg::DP_INS_PTR: begin
        ins_pos = ptr_r;
        ins_val = v_r;
      end
      default: ins_pos = '0;
    endcase
  end

  always_comb begin
    store_nxt = store_r;
    occ_nxt   = occ_r;
    case (cmd.op)
      lddq_pkg::DP_INS_FRONT, lddq_pkg::DP_INS_REAR, lddq_pkg::DP_INS_PTR: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (PW'(i) == ins_pos) begin
            store_nxt[i] = ins_val;
          end else if (PW'(i) > ins_pos && i > 0) begin
            store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
          end
        end
        occ_nxt = occ_r + PW'(1);
      end
      lddq_pkg::DP_DEL_FRONT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          store_nxt[i] = store_r[i + 1];
        end
        occ_nxt = occ_r - PW'(1);
      end
      lddq_pkg::DP_DEL_REAR: occ_nxt = occ_r - PW'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      ptr_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (cmd.v_load) begin
      v_r <= in_item_value;
    end
    if (cmd.out_load) begin
      val_r  <= cmd.out_elem ? rd_data : 32'sd0;
      st_r   <= cmd.out_status;
      last_r <= cmd.out_last;
      cnt_r  <= 5'(occ_nxt);
    end
  end

  assign out_element_value = val_r;
  assign out_status        = st_r;
  assign out_last_result   = last_r;
  assign out_element_count = cnt_r;

endmodule

// ----- sv/lddq_ctrl.sv -----
// Controller: operation decode, sorted-insert scan and display sequencing.
module lddq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  output logic                out_valid,
  input  logic                out_ready,
  output lddq_pkg::dp_cmd_t   cmd,
  input  lddq_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DISP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_xfer;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.op         = lddq_pkg::DP_NONE;
    cmd.out_status = lddq_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_opcode) inside
            lddq_pkg::OP_INS_FRONT, lddq_pkg::OP_INS_REAR: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.full) begin
                cmd.out_status = lddq_pkg::ST_FULL;
              end else begin
                cmd.op = (in_opcode == lddq_pkg::OP_INS_FRONT) ?
                         lddq_pkg::DP_INS_FRONT : lddq_pkg::DP_INS_REAR;
              end
            end
            lddq_pkg::OP_SORTED: begin
              if (stat.full) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = lddq_pkg::ST_FULL;
              end else begin
                cmd.v_load  = 1'b1;
                cmd.ptr_clr = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            lddq_pkg::OP_DEL_FRONT, lddq_pkg::OP_DEL_REAR: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.empty) begin
                cmd.out_status = lddq_pkg::ST_EMPTY;
              end else begin
                cmd.op = (in_opcode == lddq_pkg::OP_DEL_FRONT) ?
                         lddq_pkg::DP_DEL_FRONT : lddq_pkg::DP_DEL_REAR;
              end
            end
            lddq_pkg::OP_DISPLAY: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = lddq_pkg::ST_EMPTY;
              end else begin
                cmd.ptr_clr = 1'b1;
                state_nxt   = S_DISP;
              end
            end
            default: begin
              // unused opcodes: no change, plain ok
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_go) begin
          cmd.ptr_inc = 1'b1;
        end else if (out_free) begin
          cmd.op       = lddq_pkg::DP_INS_PTR;
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_elem = 1'b1;
          cmd.out_last = stat.disp_last;
          cmd.ptr_inc  = 1'b1;
          if (stat.disp_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/list_deque_with_sorted_insert_core.sv -----
// Top level of the bounded list deque with sorted insert.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid/in_ready, in_opcode, in_item_value | to block
//  out     | out_valid/out_ready, out_element_value,     | from block
//          | out_status, out_last_result,                |
//          | out_element_count                           |
//
// Inserts at either end, deletes and unused opcodes: the result register loads
//   on the input edge.
// Sorted insert: take the transfer, scan steps through the read mux past
//   elements smaller than the value, then shift the value in once the result
//   register is free. On a full list the result loads on the input edge.
// Display: one element a cycle from the same read mux, stalled while a result is held.
// Reset (rst_n low, synchronous) empties the list; stored values stay unset.
// A held result stalls the next transfer only until out_ready takes it.
module list_deque_with_sorted_insert_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_element_value,
  output logic [1:0]         out_status,
  output logic               out_last_result,
  output logic [4:0]         out_element_count
);

  // command and status between sequencer and store
  lddq_pkg::dp_cmd_t  cmd;
  lddq_pkg::dp_stat_t stat;

  lddq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lddq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_item_value     (in_item_value),
    .out_element_value (out_element_value),
    .out_status        (out_status),
    .out_last_result   (out_last_result),
    .out_element_count (out_element_count)
  );

endmodule
